@@ rtl/device_address_table_unit_defines.svh @@
// assertion helpers for the device address table
`ifndef DEVICE_ADDRESS_TABLE_UNIT_DEFINES_SVH
`define DEVICE_ADDRESS_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define DAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dat_pkg.sv @@
package dat_pkg;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int KIND_W = 2;
  localparam int MODE_W = 2;
  localparam int STAT_W = 3;
  localparam int SLOTO_W = 4;
  localparam int CNTO_W  = 5;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

  localparam logic [MODE_W-1:0] MODE_MAC = 2'b10;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_ZERO_MAC = 3'd4;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [IP_W-1:0]  mask;
    logic [MAC_W-1:0] mac;
  } entry_t;

  // search key broadcast to every cell during a scan
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
  } key_t;

  // search token handed from cell to cell (slot indexes travel beside it)
  typedef struct packed {
    logic   valid;
    logic   found;
    logic   free_found;
    entry_t data;
  } scan_t;

  // table update: add and delete are applied by the cell whose index matches the write slot, clear-all by every cell
  typedef struct packed {
    logic   add;
    logic   del;
    logic   clr_all;
    entry_t data;
  } tbl_wr_t;

endpackage

@@ rtl/dat_cell.sv @@
module dat_cell #(
  parameter int SLOT_W = 4,
  parameter int INDEX  = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  dat_pkg::key_t       key,
  input  dat_pkg::tbl_wr_t    wr,
  input  logic [SLOT_W-1:0]   wr_slot,
  input  dat_pkg::scan_t      tok_in,
  input  logic [SLOT_W-1:0]   hit_slot_in,
  input  logic [SLOT_W-1:0]   free_slot_in,
  output dat_pkg::scan_t      tok_out,
  output logic [SLOT_W-1:0]   hit_slot_out,
  output logic [SLOT_W-1:0]   free_slot_out
);
  import dat_pkg::*;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

  logic   valid;
  entry_t entry;
  logic   match;
  logic   sel;

  assign sel   = (wr_slot == MY_SLOT);
  assign match = valid
               && (!key.mode[0] || (entry.ip == key.ip))
               && (!key.mode[1] || (entry.mac == key.mac));

  // stored entry
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.clr_all) begin
      valid <= 1'b0;
    end else if (sel && wr.add) begin
      valid <= 1'b1;
    end else if (sel && wr.del) begin
      valid <= 1'b0;
    end
    if (sel && wr.add) begin
      entry <= wr.data;
    end
  end

  // token stage: first hit and first free slot so far
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.found      <= tok_in.found || match;
    tok_out.free_found <= tok_in.free_found || !valid;
    if (!tok_in.found && match) begin
      tok_out.data <= entry;
      hit_slot_out <= MY_SLOT;
    end else begin
      tok_out.data <= tok_in.data;
      hit_slot_out <= hit_slot_in;
    end
    if (!tok_in.free_found && !valid) begin
      free_slot_out <= MY_SLOT;
    end else begin
      free_slot_out <= free_slot_in;
    end
  end

endmodule

@@ rtl/device_address_table_unit.sv @@
// device address table: ENTRIES records of ip, netmask and 48-bit mac, held
// in a row of cells, one record per cell. every request word starts a search
// token that walks the row one cell per clock, picking up the first matching
// record and the first free slot in slot order; at the end of the row the
// controller decides the outcome, writes the one affected cell (or clears
// all) and loads the response register. a new request is accepted only
// after the previous one has walked the cell row and been decided; the
// response sits in its own register, so a new request is taken while an old
// response waits. operations: lookup (match mode bit0 ip, bit1 mac, zero
// matches any valid record), add, delete and clear all. there is no
// clearing pass after reset: the valid bits of all cells clear at once.
module device_address_table_unit #(
  parameter int ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // kind[1:0], match_mode[3:2], ip_addr[35:4], net_mask[67:36],
  // mac_addr[115:68], zero pad[119:116]
  input  logic [119:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], hit[3], slot[7:4], found_ip[39:8], found_mask[71:40],
  // found_mac[119:72], entry_count[124:120], zero pad[127:125]
  output logic [127:0] m_tdata
);
  import dat_pkg::*;

  `include "device_address_table_unit_defines.svh"

  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int SX_W   = (SLOT_W > SLOTO_W) ? SLOT_W : SLOTO_W;
  localparam int CX_W   = (CNT_W > CNTO_W) ? CNT_W : CNTO_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  typedef enum logic [1:0] {IDLE, SCAN, DECIDE} state_t;

  state_t state;

  // request held for the whole operation
  logic [KIND_W-1:0] kind;
  key_t              key;
  logic [IP_W-1:0]   net_mask;
  logic              start;

  // used-record count
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // token from the end of the row
  scan_t             done;
  logic [SLOT_W-1:0] done_hit_slot;
  logic [SLOT_W-1:0] done_free_slot;

  // response register
  logic [STAT_W-1:0] status;
  logic              hit;
  logic [SLOTO_W-1:0] slot;
  entry_t            found;

  // response and update worked out from the finished token
  logic [STAT_W-1:0] status_next;
  logic              hit_next;
  logic [SLOT_W-1:0] slot_next;
  entry_t            found_next;
  tbl_wr_t           wr;
  logic [SLOT_W-1:0] wr_slot;
  logic              fire;
  logic [SX_W-1:0]   slot_ext;
  logic [CX_W-1:0]   count_ext;

  // cell row
  scan_t             tok       [ENTRIES+1];
  logic [SLOT_W-1:0] hit_slot  [ENTRIES+1];
  logic [SLOT_W-1:0] free_slot [ENTRIES+1];

  logic s_fire;

  assign s_tready = (state == IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign fire     = (state == DECIDE) && (!m_tvalid || m_tready);

  // fresh token enters cell 0 the cycle after accept
  assign tok[0].valid      = start;
  assign tok[0].found      = 1'b0;
  assign tok[0].free_found = 1'b0;
  assign tok[0].data       = '0;
  assign hit_slot[0]       = '0;
  assign free_slot[0]      = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    dat_cell #(
      .SLOT_W (SLOT_W),
      .INDEX  (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .key           (key),
      .wr            (wr),
      .wr_slot       (wr_slot),
      .tok_in        (tok[i]),
      .hit_slot_in   (hit_slot[i]),
      .free_slot_in  (free_slot[i]),
      .tok_out       (tok[i+1]),
      .hit_slot_out  (hit_slot[i+1]),
      .free_slot_out (free_slot[i+1])
    );
  end

  // outcome of the operation
  always_comb begin
    status_next = ST_OK;
    hit_next    = 1'b0;
    slot_next   = '0;
    found_next  = '0;
    count_next  = count;
    wr          = '0;
    wr.data.ip  = key.ip;
    wr.data.mask = net_mask;
    wr.data.mac = key.mac;
    wr_slot     = done_free_slot;
    case (kind)
      KIND_LOOKUP: begin
        if (done.found) begin
          hit_next   = 1'b1;
          slot_next  = done_hit_slot;
          found_next = done.data;
        end
      end
      KIND_ADD: begin
        if (key.mac == '0) begin
          status_next = ST_ZERO_MAC;
        end else if (count == FULL_CNT) begin
          status_next = ST_FULL;
        end else if (done.found) begin
          status_next = ST_DUP;
          hit_next    = 1'b1;
          slot_next   = done_hit_slot;
          found_next  = done.data;
        end else if (!done.free_found) begin
          status_next = ST_FULL;
        end else begin
          slot_next  = done_free_slot;
          wr.add     = fire;
          count_next = count + 1'b1;
        end
      end
      KIND_DELETE: begin
        wr_slot = done_hit_slot;
        if (key.mac == '0) begin
          status_next = ST_ZERO_MAC;
        end else if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (done.found) begin
          hit_next   = 1'b1;
          slot_next  = done_hit_slot;
          found_next = done.data;
          wr.del     = fire;
          count_next = count - 1'b1;
        end
      end
      KIND_CLEAR: begin
        wr.clr_all = fire;
        count_next = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  assign slot_ext = SX_W'(slot_next);

  // control and response registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      start    <= 1'b0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      start <= s_fire;
      // a new response word replaces the one taken in the same cycle
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_fire) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (tok[ENTRIES].valid) begin
            state <= DECIDE;
          end
        end
        DECIDE: begin
          if (fire) begin
            state <= IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
    if (s_fire) begin
      kind     <= s_tdata[1:0];
      key.mode <= (s_tdata[1:0] == KIND_LOOKUP) ? s_tdata[3:2] : MODE_MAC;
      key.ip   <= s_tdata[35:4];
      net_mask <= s_tdata[67:36];
      key.mac  <= s_tdata[115:68];
    end
    if (state == SCAN && tok[ENTRIES].valid) begin
      done           <= tok[ENTRIES];
      done_hit_slot  <= hit_slot[ENTRIES];
      done_free_slot <= free_slot[ENTRIES];
    end
    if (fire) begin
      status <= status_next;
      hit    <= hit_next;
      slot   <= slot_ext[SLOTO_W-1:0];
      found  <= found_next;
    end
  end

  assign count_ext = CX_W'(count);

  assign m_tdata = {3'b000, count_ext[CNTO_W-1:0], found.mac, found.mask, found.ip,
                    slot, hit, status};

  // the count never passes the table size
  `DAT_ASSERT_NOW(a_count_range, 1'b1, count <= FULL_CNT, "used count above table size")
  // a token leaves the row only while a scan is running
  `DAT_ASSERT_NOW(a_tail_in_scan, tok[ENTRIES].valid, state == SCAN,
    "search token left the row outside a scan")
  // a successful add bumps the count by one
  `DAT_ASSERT_NEXT(a_add_count, wr.add, count == $past(count) + 1'b1,
    "add did not bump the used count")
  // a clear-all empties the table
  `DAT_ASSERT_NEXT(a_clear_count, wr.clr_all, count == '0, "clear all left records counted")

endmodule
